>>> sv/adcs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ADC channel scan sequencer.
// No dependencies; the other files of the block, but for adcs_checker, import this package.
package adcs_pkg;

	localparam int SAMPLE_W = 12;
	localparam int CHAN_W = 4;
	localparam int MUX_W = 3;
	localparam int SETTLE_W = 8;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SETTLE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_SETTLE = 4'd1;

	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd1;

	typedef struct packed {
		logic              disable_valid;
		logic [CHAN_W-1:0] disable_channel;
		logic              enable_valid;
		logic [CHAN_W-1:0] enable_channel;
		logic              mux_valid;
		logic [MUX_W-1:0]  mux_address;
		logic              start_conversion;
		logic              sample_stored;
		logic [CHAN_W-1:0] stored_channel;
		logic              scan_ready;
	} adcs_cmd_t;

endpackage

>>> sv/adcs_in_if.sv
`timescale 1ns / 1ps
// Input channel of the scan sequencer: one tick beat per transfer.
// Depends on adcs_pkg for the field widths.
interface adcs_in_if;
	import adcs_pkg::*;

	logic                valid;
	logic                ready;
	logic                data_ready;
	logic [SAMPLE_W-1:0] sample;
	logic [CHAN_W-1:0]   read_index;

	modport source (output valid, output data_ready, output sample, output read_index,
		input ready);
	modport sink (input valid, input data_ready, input sample, input read_index,
		output ready);

endinterface

>>> sv/adcs_out_if.sv
`timescale 1ns / 1ps
// Result channel of the scan sequencer: one command and readback beat per tick.
// Depends on adcs_pkg for the field widths.
interface adcs_out_if;
	import adcs_pkg::*;

	logic                valid;
	logic                ready;
	logic                disable_valid;
	logic [CHAN_W-1:0]   disable_channel;
	logic                enable_valid;
	logic [CHAN_W-1:0]   enable_channel;
	logic                mux_valid;
	logic [MUX_W-1:0]    mux_address;
	logic                start_conversion;
	logic                sample_stored;
	logic [CHAN_W-1:0]   stored_channel;
	logic                scan_ready;
	logic [SAMPLE_W-1:0] read_value;

	modport source (output valid, output disable_valid, output disable_channel,
		output enable_valid, output enable_channel, output mux_valid, output mux_address,
		output start_conversion, output sample_stored, output stored_channel,
		output scan_ready, output read_value, input ready);
	modport sink (input valid, input disable_valid, input disable_channel,
		input enable_valid, input enable_channel, input mux_valid, input mux_address,
		input start_conversion, input sample_stored, input stored_channel,
		input scan_ready, input read_value, output ready);

endinterface

>>> sv/adcs_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel of the scan sequencer: register index and data.
// Depends on adcs_pkg for the field widths.
interface adcs_cfg_if;
	import adcs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SETTLE_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);

endinterface

>>> sv/adcs_phase_fsm.sv
`timescale 1ns / 1ps
// Phase machine of the scan sequencer: channel counter, settle timer and ready flag.
// Depends on adcs_pkg for the command struct; advances once per processed tick.
module adcs_phase_fsm #(
	parameter int CHANNEL_COUNT = 16,
	parameter int DIRECT_CHANNELS = 12,
	parameter int CH_W = $clog2(CHANNEL_COUNT)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         data_ready,
	input  logic [adcs_pkg::SETTLE_W-1:0] first_settle,
	input  logic [adcs_pkg::SETTLE_W-1:0] second_settle,
	output adcs_pkg::adcs_cmd_t          cmd,
	output logic                         store_en,
	output logic [CH_W-1:0]              store_channel
);
	import adcs_pkg::*;

	localparam int SHARED = DIRECT_CHANNELS - 1;

	typedef enum logic [2:0] {
		PH_DISABLE     = 3'd0,
		PH_FIRST_WAIT  = 3'd1,
		PH_SECOND_WAIT = 3'd2,
		PH_START       = 3'd3,
		PH_WAIT_DATA   = 3'd4,
		PH_FINISH      = 3'd5
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [CH_W-1:0]     ch_q, ch_d;
	logic [SETTLE_W-1:0] timer_q, timer_d;
	logic                ready_q, ready_d;

	always_comb begin
		logic [SETTLE_W-1:0] tdec;
		int                  offset;
		tdec = timer_q - 8'd1;
		offset = int'(ch_q) - SHARED;
		phase_d = phase_q;
		ch_d = ch_q;
		timer_d = timer_q;
		ready_d = ready_q;
		cmd = '0;
		cmd.stored_channel = CHAN_W'(ch_q);
		case (phase_q)
			PH_FIRST_WAIT: begin
				timer_d = tdec;
				if (tdec == '0) begin
					cmd.enable_valid = 1'b1;
					if (int'(ch_q) >= SHARED) begin
						cmd.enable_channel = CHAN_W'(SHARED);
						if (offset <= 7) begin
							cmd.mux_valid = 1'b1;
							cmd.mux_address = MUX_W'(offset);
						end
					end else begin
						cmd.enable_channel = CHAN_W'(ch_q);
					end
					timer_d = second_settle;
					phase_d = PH_SECOND_WAIT;
				end
			end
			PH_SECOND_WAIT: begin
				timer_d = tdec;
				if (tdec == '0) begin
					phase_d = PH_START;
				end
			end
			PH_START: begin
				cmd.start_conversion = 1'b1;
				phase_d = PH_WAIT_DATA;
			end
			PH_WAIT_DATA: begin
				if (data_ready) begin
					cmd.sample_stored = 1'b1;
					phase_d = PH_FINISH;
				end
			end
			PH_FINISH: begin
				if (ch_q == CH_W'(CHANNEL_COUNT - 1)) begin
					ch_d = '0;
					ready_d = 1'b1;
				end else begin
					ch_d = ch_q + 1'b1;
				end
				phase_d = PH_DISABLE;
			end
			default: begin
				if (int'(ch_q) < DIRECT_CHANNELS) begin
					cmd.disable_valid = 1'b1;
					cmd.disable_channel = (ch_q == '0) ? CHAN_W'(SHARED)
						: CHAN_W'(int'(ch_q) - 1);
				end
				timer_d = first_settle;
				phase_d = PH_FIRST_WAIT;
			end
		endcase
		cmd.scan_ready = ready_d;
	end

	assign store_en = advance && cmd.sample_stored;
	assign store_channel = ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DISABLE;
			ch_q <= '0;
			timer_q <= '0;
			ready_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			ch_q <= ch_d;
			timer_q <= timer_d;
			ready_q <= ready_d;
		end
	end

endmodule

>>> sv/adcs_sample_table.sv
`timescale 1ns / 1ps
// Sample table of the scan sequencer: one write port and one registered read port.
// Depends on adcs_pkg for the readback width; valid bits stand for the reset clear.
module adcs_sample_table #(
	parameter int CHANNEL_COUNT = 16,
	parameter int SAMPLE_BITS = 12,
	parameter int CH_W = $clog2(CHANNEL_COUNT)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [CH_W-1:0]               wr_index,
	input  logic [adcs_pkg::SAMPLE_W-1:0] wr_sample,
	input  logic                          rd_en,
	input  logic [adcs_pkg::CHAN_W-1:0]   rd_index,
	output logic [adcs_pkg::SAMPLE_W-1:0] rd_value
);
	import adcs_pkg::*;

	logic [SAMPLE_BITS-1:0]   mem [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] filled_q;
	logic [SAMPLE_BITS-1:0]   wr_data;
	logic [SAMPLE_BITS-1:0]   rd_q;
	logic [CH_W-1:0]          rd_addr;
	logic                     rd_in_range;

	assign wr_data = SAMPLE_BITS'(wr_sample);
	assign rd_in_range = int'(rd_index) < CHANNEL_COUNT;
	assign rd_addr = CH_W'(rd_index);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_index] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (wr_en) begin
			filled_q[wr_index] <= 1'b1;
		end
	end

	// The readback shows the table after this beat's write.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (!rd_in_range) begin
				rd_q <= '0;
			end else if (wr_en && wr_index == rd_addr) begin
				rd_q <= wr_data;
			end else if (!filled_q[rd_addr]) begin
				rd_q <= '0;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_value = SAMPLE_W'(rd_q);

endmodule

>>> sv/adc_channel_scan_sequencer_core.sv
`timescale 1ns / 1ps
// ADC channel scan sequencer: one tick beat in gives one command and readback beat out.
// The core takes a new tick every clock cycle unless the result channel stalls; a beat
// passes an input register and then the result register, and the result register lets
// the next tick enter while a finished beat waits. The phase machine and
// the registered read port of the sample table both advance once per beat. The table
// reads as zero after reset through per-entry valid bits, so there is no clearing pass.
// Configuration writes are taken in any cycle; write them only while the core is idle.
// Depends on adcs_pkg, the adcs interfaces, adcs_phase_fsm and adcs_sample_table.
module adc_channel_scan_sequencer_core #(
	parameter int CHANNEL_COUNT = 16,
	parameter int DIRECT_CHANNELS = 12,
	parameter int SAMPLE_BITS = 12
) (
	input logic        clk,
	input logic        arst_n,
	adcs_in_if.sink    samples,
	adcs_out_if.source results,
	adcs_cfg_if.sink   cfg
);
	import adcs_pkg::*;

	localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	logic                valid_s1;
	logic                data_ready_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [CHAN_W-1:0]   read_index_s1;
	logic                advance;
	logic                out_valid_q;
	adcs_cmd_t           cmd;
	adcs_cmd_t           cmd_q;
	logic                store_en;
	logic [CH_W-1:0]     store_channel;
	logic [SETTLE_W-1:0] first_settle_q;
	logic [SETTLE_W-1:0] second_settle_q;

	assign advance = valid_s1 && (!out_valid_q || results.ready);
	assign samples.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_settle_q <= SETTLE_RESET;
			second_settle_q <= SETTLE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FIRST_SETTLE: first_settle_q <= cfg.data;
				REG_SECOND_SETTLE: second_settle_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			data_ready_s1 <= samples.data_ready;
			sample_s1 <= samples.sample;
			read_index_s1 <= samples.read_index;
		end
	end

	adcs_phase_fsm #(
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.DIRECT_CHANNELS(DIRECT_CHANNELS),
		.CH_W(CH_W)
	) u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.data_ready(data_ready_s1),
		.first_settle(first_settle_q),
		.second_settle(second_settle_q),
		.cmd(cmd),
		.store_en(store_en),
		.store_channel(store_channel)
	);

	adcs_sample_table #(
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.SAMPLE_BITS(SAMPLE_BITS),
		.CH_W(CH_W)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(store_en),
		.wr_index(store_channel),
		.wr_sample(sample_s1),
		.rd_en(advance),
		.rd_index(read_index_s1),
		.rd_value(results.read_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_q <= cmd;
		end
	end

	assign results.valid = out_valid_q;
	assign results.disable_valid = cmd_q.disable_valid;
	assign results.disable_channel = cmd_q.disable_channel;
	assign results.enable_valid = cmd_q.enable_valid;
	assign results.enable_channel = cmd_q.enable_channel;
	assign results.mux_valid = cmd_q.mux_valid;
	assign results.mux_address = cmd_q.mux_address;
	assign results.start_conversion = cmd_q.start_conversion;
	assign results.sample_stored = cmd_q.sample_stored;
	assign results.stored_channel = cmd_q.stored_channel;
	assign results.scan_ready = cmd_q.scan_ready;

endmodule

>>> sv/adcs_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the scan sequencer core, and the bind that attaches them.
// Depends on adc_channel_scan_sequencer_core and its interfaces.
module adcs_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic disable_valid,
	input logic enable_valid,
	input logic mux_valid,
	input logic start_conversion,
	input logic sample_stored,
	input logic scan_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result beat dropped while stalled.");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({disable_valid, enable_valid, start_conversion,
			sample_stored}) <= 1)
		else $error("More than one converter command in one beat.");

	a_mux_with_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mux_valid |-> enable_valid)
		else $error("Multiplexer address driven without a channel enable.");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scan_ready |=> !out_valid || scan_ready)
		else $error("Scan ready flag cleared after it was set.");

endmodule

bind adc_channel_scan_sequencer_core adcs_checker u_adcs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.disable_valid(results.disable_valid),
	.enable_valid(results.enable_valid),
	.mux_valid(results.mux_valid),
	.start_conversion(results.start_conversion),
	.sample_stored(results.sample_stored),
	.scan_ready(results.scan_ready)
);

>>> bench/tb_adc_channel_scan_sequencer_core.sv
`timescale 1ns / 1ps
// Testbench for adc_channel_scan_sequencer_core: drives tick beats, predicts every result beat
// with a behavioral sequencer model and checks the results field by field in order.
// Depends on adcs_pkg, the adcs interfaces and the core itself.
module tb_adc_channel_scan_sequencer_core;
	import adcs_pkg::*;

	localparam int CHANNEL_COUNT = 16;
	localparam int DIRECT_CHANNELS = 12;
	localparam int SAMPLE_BITS = 12;
	localparam int HOLD_CYCLES = 64;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

	typedef enum logic [2:0] {
		PH_DISABLE = 3'd0,
		PH_FIRST_WAIT = 3'd1,
		PH_SECOND_WAIT = 3'd2,
		PH_START = 3'd3,
		PH_DATA_WAIT = 3'd4,
		PH_FINISH = 3'd5
	} scan_phase_t;

	typedef struct packed {
		adcs_cmd_t           cmd;
		logic [SAMPLE_W-1:0] read_value;
	} scan_result_t;

	logic clk;
	logic arst_n;

	adcs_in_if  samples_if ();
	adcs_out_if results_if ();
	adcs_cfg_if cfg_if ();

	adc_channel_scan_sequencer_core #(
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.DIRECT_CHANNELS(DIRECT_CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg(cfg_if)
	);

	scan_phase_t          seq_phase;
	logic [CHAN_W-1:0]    seq_channel;
	logic [SETTLE_W-1:0]  settle_count;
	logic [SETTLE_W-1:0]  first_settle;
	logic [SETTLE_W-1:0]  second_settle;
	logic [SAMPLE_W-1:0]  sample_mem [CHANNEL_COUNT];
	logic                 scan_done;

	scan_result_t expected_cmds [$];
	int unsigned  mismatch_count = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;
	bit           hold_pending = 1'b0;
	int unsigned  hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("tb_adc_channel_scan_sequencer_core NOT OK");
		$finish;
	end

	task automatic reset_sequencer();
		seq_phase = PH_DISABLE;
		seq_channel = '0;
		settle_count = '0;
		first_settle = SETTLE_RESET;
		second_settle = SETTLE_RESET;
		scan_done = 1'b0;
		for (int i = 0; i < CHANNEL_COUNT; i++)
			sample_mem[i] = '0;
	endtask

	function automatic scan_result_t step_sequencer(input logic rdy,
		input logic [SAMPLE_W-1:0] smp, input logic [CHAN_W-1:0] ridx);
		scan_result_t r;
		int off;
		r = '0;
		r.cmd.stored_channel = seq_channel;
		case (seq_phase)
		PH_FIRST_WAIT: begin
			settle_count = settle_count - 1'b1;
			if (settle_count == 0) begin
				r.cmd.enable_valid = 1'b1;
				if (seq_channel >= CHAN_W'(DIRECT_CHANNELS - 1)) begin
					off = int'(seq_channel) - (DIRECT_CHANNELS - 1);
					if (off <= 7) begin
						r.cmd.mux_valid = 1'b1;
						r.cmd.mux_address = MUX_W'(off);
					end
					r.cmd.enable_channel = CHAN_W'(DIRECT_CHANNELS - 1);
				end else begin
					r.cmd.enable_channel = seq_channel;
				end
				settle_count = second_settle;
				seq_phase = PH_SECOND_WAIT;
			end
		end
		PH_SECOND_WAIT: begin
			settle_count = settle_count - 1'b1;
			if (settle_count == 0)
				seq_phase = PH_START;
		end
		PH_START: begin
			r.cmd.start_conversion = 1'b1;
			seq_phase = PH_DATA_WAIT;
		end
		PH_DATA_WAIT: begin
			if (rdy) begin
				sample_mem[seq_channel] = smp;
				r.cmd.sample_stored = 1'b1;
				seq_phase = PH_FINISH;
			end
		end
		PH_FINISH: begin
			if (seq_channel == CHAN_W'(CHANNEL_COUNT - 1)) begin
				seq_channel = '0;
				scan_done = 1'b1;
			end else begin
				seq_channel = seq_channel + 1'b1;
			end
			seq_phase = PH_DISABLE;
		end
		default: begin
			if (seq_channel < CHAN_W'(DIRECT_CHANNELS)) begin
				r.cmd.disable_valid = 1'b1;
				r.cmd.disable_channel = (seq_channel == 0) ? CHAN_W'(DIRECT_CHANNELS - 1)
					: seq_channel - 1'b1;
			end
			settle_count = first_settle;
			seq_phase = PH_FIRST_WAIT;
		end
		endcase
		r.cmd.scan_ready = scan_done;
		r.read_value = sample_mem[ridx];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("mismatch on %0s at %0t: got %0h, expected %0h", what, $time, got, want);
	endtask

	task automatic check_field(input string what, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// The receiver stalls at random, or for a long stretch when a hold-off is requested.
	initial begin
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		scan_result_t got;
		scan_result_t want;
		if (arst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			got.cmd.disable_valid = results_if.disable_valid;
			got.cmd.disable_channel = results_if.disable_channel;
			got.cmd.enable_valid = results_if.enable_valid;
			got.cmd.enable_channel = results_if.enable_channel;
			got.cmd.mux_valid = results_if.mux_valid;
			got.cmd.mux_address = results_if.mux_address;
			got.cmd.start_conversion = results_if.start_conversion;
			got.cmd.sample_stored = results_if.sample_stored;
			got.cmd.stored_channel = results_if.stored_channel;
			got.cmd.scan_ready = results_if.scan_ready;
			got.read_value = results_if.read_value;
			if (expected_cmds.size() == 0) begin
				report_mismatch("unexpected result beat", 16'(got.read_value), '0);
			end else begin
				want = expected_cmds.pop_front();
				check_field("disable_valid", 16'(got.cmd.disable_valid),
					16'(want.cmd.disable_valid));
				check_field("disable_channel", 16'(got.cmd.disable_channel),
					16'(want.cmd.disable_channel));
				check_field("enable_valid", 16'(got.cmd.enable_valid),
					16'(want.cmd.enable_valid));
				check_field("enable_channel", 16'(got.cmd.enable_channel),
					16'(want.cmd.enable_channel));
				check_field("mux_valid", 16'(got.cmd.mux_valid), 16'(want.cmd.mux_valid));
				check_field("mux_address", 16'(got.cmd.mux_address),
					16'(want.cmd.mux_address));
				check_field("start_conversion", 16'(got.cmd.start_conversion),
					16'(want.cmd.start_conversion));
				check_field("sample_stored", 16'(got.cmd.sample_stored),
					16'(want.cmd.sample_stored));
				check_field("stored_channel", 16'(got.cmd.stored_channel),
					16'(want.cmd.stored_channel));
				check_field("scan_ready", 16'(got.cmd.scan_ready), 16'(want.cmd.scan_ready));
				check_field("read_value", 16'(got.read_value), 16'(want.read_value));
			end
		end
	end

	task automatic send_tick(input logic rdy, input logic [SAMPLE_W-1:0] smp,
		input logic [CHAN_W-1:0] ridx);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap != 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.data_ready <= rdy;
		samples_if.sample <= smp;
		samples_if.read_index <= ridx;
		do
			@(posedge clk);
		while (samples_if.ready !== 1'b1);
		expected_cmds.push_back(step_sequencer(rdy, smp, ridx));
	endtask

	task automatic drain_results();
		samples_if.valid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_settle(input logic [SETTLE_W-1:0] first_val,
		input logic [SETTLE_W-1:0] second_val, input bit poke_unused);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [SETTLE_W-1:0]  val [3];
		int n;
		idx[0] = REG_FIRST_SETTLE;
		val[0] = first_val;
		idx[1] = REG_SECOND_SETTLE;
		val[1] = second_val;
		idx[2] = REG_UNUSED;
		val[2] = SETTLE_W'($urandom);
		n = poke_unused ? 3 : 2;
		drain_results();
		for (int i = 0; i < n; i++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= idx[i];
			cfg_if.data <= val[i];
			do
				@(posedge clk);
			while (cfg_if.ready !== 1'b1);
			case (idx[i])
			REG_FIRST_SETTLE: first_settle = val[i];
			REG_SECOND_SETTLE: second_settle = val[i];
			default: ;
			endcase
		end
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random_ticks(input int unsigned count, input int unsigned ready_pct);
		logic [SAMPLE_W-1:0] smp;
		int unsigned seg;
		for (int unsigned k = 0; k < count; k++) begin
			seg = (k * 3) / count;
			case (seg)
			0: begin
				send_idle_pct = 27;
				recv_stall_pct = 74;
			end
			1: begin
				send_idle_pct = 74;
				recv_stall_pct = 27;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			endcase
			case ($urandom_range(7))
			0: smp = '0;
			1: smp = '1;
			default: smp = SAMPLE_W'($urandom_range(4095));
			endcase
			send_tick($urandom_range(99) < ready_pct, smp, CHAN_W'($urandom_range(15)));
		end
	endtask

	task automatic test_directed_scan();
		logic [SAMPLE_W-1:0] pattern [4];
		pattern[0] = 12'hFFF;
		pattern[1] = 12'h000;
		pattern[2] = 12'hA5A;
		pattern[3] = 12'h5A5;
		send_idle_pct = 27;
		recv_stall_pct = 74;
		for (int i = 0; i < 25; i++)
			send_tick(i != 4, pattern[i % 4], (i < 16) ? CHAN_W'(15 - i) : CHAN_W'(i % 3));
	endtask

	task automatic test_default_scan();
		run_random_ticks(250, 40);
	endtask

	task automatic test_output_backpressure();
		hold_pending = 1'b1;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 80; i++)
			send_tick(1'($urandom_range(1)), SAMPLE_W'($urandom), CHAN_W'($urandom));
	endtask

	task automatic test_mid_settle();
		program_settle(SETTLE_W'($urandom_range(8, 2)), SETTLE_W'($urandom_range(8, 2)), 1'b1);
		run_random_ticks(150, 50);
	endtask

	task automatic test_long_settle();
		program_settle(8'd255, 8'd255, 1'b0);
		run_random_ticks(230, 50);
	endtask

	task automatic test_zero_second_settle();
		program_settle(8'd1, 8'd0, 1'b1);
		run_random_ticks(200, 50);
	endtask

	task automatic test_zero_first_settle();
		program_settle(8'd0, 8'd1, 1'b0);
		run_random_ticks(280, 50);
	endtask

	initial begin
		arst_n <= 1'b0;
		samples_if.valid <= 1'b0;
		samples_if.data_ready <= 1'b0;
		samples_if.sample <= '0;
		samples_if.read_index <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data <= '0;
		reset_sequencer();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_scan();
		test_default_scan();
		test_output_backpressure();
		test_mid_settle();
		test_long_settle();
		test_zero_second_settle();
		test_zero_first_settle();
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_cmds.size() == 0) begin
			$display("tb_adc_channel_scan_sequencer_core OK");
		end else begin
			$display("tb_adc_channel_scan_sequencer_core NOT OK");
		end
		$finish;
	end

endmodule
